@@ rtl/smau_pkg.sv @@
// ----------------------------------------------------------------------------
// smau_pkg
// shared types, constants and helpers of the small matrix arithmetic unit
// ----------------------------------------------------------------------------
package smau_pkg;

  // matrix geometry
  localparam int unsigned MAX_DIM = 8;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM);
  localparam int unsigned SIZE_W  = DIM_W + 1;
  localparam int unsigned ADDR_W  = 2 * DIM_W;
  localparam int unsigned DEPTH   = MAX_DIM * MAX_DIM;

  // data widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned ACC_W   = PROD_W + $clog2(MAX_DIM);
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned SHIFT_W = ACC_W - FRAC_W;

  // configuration port
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 32;

  // request commands
  typedef enum logic [1:0] {
    CMD_LOAD_A = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_START  = 2'd2
  } cmd_e;

  // operation modes
  typedef enum logic [2:0] {
    MODE_MUL    = 3'd0,
    MODE_MUL_BT = 3'd1,
    MODE_ADD    = 3'd2,
    MODE_SUB    = 3'd3,
    MODE_SCALE  = 3'd4,
    MODE_TRANS  = 3'd5
  } mode_e;

  // register indexes
  typedef enum logic [2:0] {
    REG_OP_MODE = 3'd0,
    REG_ROWS_A  = 3'd1,
    REG_COLS_A  = 3'd2,
    REG_ROWS_B  = 3'd3,
    REG_COLS_B  = 3'd4,
    REG_SCALE   = 3'd5
  } reg_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_DRAIN = 2'd2
  } state_e;

  // tag that travels with each memory read through the datapath
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             lastk;
    logic             fin;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
  } tag_t;

  // clamp a size register to 1..MAX_DIM and return the last index
  function automatic logic [DIM_W-1:0] dim_last(input logic [SIZE_W-1:0] d);
    logic [DIM_W-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (d > SIZE_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM - 1);
    end else begin
      r = DIM_W'(d - SIZE_W'(1));
    end
    return r;
  endfunction

endpackage

@@ rtl/smau_datapath.sv @@
// ----------------------------------------------------------------------------
// smau_datapath
// multiply or add stage, wide accumulator and saturating result register
// ----------------------------------------------------------------------------
module smau_datapath import smau_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [2:0]               mode_i,
  input  logic signed [DATA_W-1:0] scale_i,
  input  logic signed [DATA_W-1:0] rd_a_i,
  input  logic signed [DATA_W-1:0] rd_b_i,
  input  tag_t                     tag_i,
  input  logic                     err_req_i,
  output logic                     result_valid_o,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic [DIM_W-1:0]         out_row_o,
  output logic [DIM_W-1:0]         out_col_o,
  output logic                     last_o,
  output logic                     error_o,
  output logic                     fin_emit_o
);

  logic signed [DATA_W-1:0] op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [DATA_W:0]   add_s;
  logic signed [DATA_W:0]   sub_s;
  logic signed [PROD_W-1:0] term_d, term_q;
  tag_t                     tag2_q;
  logic signed [ACC_W-1:0]  term_ext;
  logic signed [ACC_W-1:0]  acc_q;
  logic                     done_q;
  logic                     fin3_q;
  logic [DIM_W-1:0]         row3_q, col3_q;
  logic [SHIFT_W-1:0]       shifted;
  logic                     fits;
  logic [DATA_W-1:0]        sat_val;
  logic                     valid_q, last_q, error_q;
  logic [DATA_W-1:0]        value_q;
  logic [DIM_W-1:0]         row_q, col_q;

  // one multiplier, shared by the multiply modes and scale
  always_comb begin
    op_b  = (mode_i == MODE_SCALE) ? scale_i : rd_b_i;
    prod  = rd_a_i * op_b;
    add_s = {rd_a_i[DATA_W-1], rd_a_i} + {rd_b_i[DATA_W-1], rd_b_i};
    sub_s = {rd_a_i[DATA_W-1], rd_a_i} - {rd_b_i[DATA_W-1], rd_b_i};
  end

  // term in units of 2^-32, so every mode shares the accumulator
  always_comb begin
    case (mode_i)
      MODE_MUL, MODE_MUL_BT, MODE_SCALE: term_d = prod;
      MODE_ADD: term_d = {{(PROD_W-DATA_W-1-FRAC_W){add_s[DATA_W]}}, add_s, {FRAC_W{1'b0}}};
      MODE_SUB: term_d = {{(PROD_W-DATA_W-1-FRAC_W){sub_s[DATA_W]}}, sub_s, {FRAC_W{1'b0}}};
      default:  term_d = {{(PROD_W-DATA_W-FRAC_W){rd_a_i[DATA_W-1]}}, rd_a_i, {FRAC_W{1'b0}}};
    endcase
  end

  // term register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q <= '0;
    end else begin
      tag2_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
  end

  assign term_ext = {{(ACC_W-PROD_W){term_q[PROD_W-1]}}, term_q};

  // accumulator, restarted on the first term of each element
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tag2_q.valid & tag2_q.lastk;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag2_q.valid) begin
      acc_q  <= tag2_q.first ? term_ext : acc_q + term_ext;
      fin3_q <= tag2_q.fin;
      row3_q <= tag2_q.row;
      col3_q <= tag2_q.col;
    end
  end

  // floor shift by the fraction width and saturate to 32 bits
  always_comb begin
    shifted = acc_q[ACC_W-1:FRAC_W];
    fits    = (&shifted[SHIFT_W-1:DATA_W-1]) | ~(|shifted[SHIFT_W-1:DATA_W-1]);
    if (fits) begin
      sat_val = shifted[DATA_W-1:0];
    end else if (shifted[SHIFT_W-1]) begin
      sat_val = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= done_q | err_req_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (err_req_i) begin
      value_q <= '0;
      row_q   <= '0;
      col_q   <= '0;
      last_q  <= 1'b1;
      error_q <= 1'b1;
    end else begin
      value_q <= sat_val;
      row_q   <= row3_q;
      col_q   <= col3_q;
      last_q  <= fin3_q;
      error_q <= 1'b0;
    end
  end

  assign fin_emit_o     = done_q & fin3_q;
  assign result_valid_o = valid_q;
  assign result_value_o = value_q;
  assign out_row_o      = row_q;
  assign out_col_o      = col_q;
  assign last_o         = last_q;
  assign error_o        = error_q;

endmodule

@@ rtl/small_matrix_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// small_matrix_arithmetic_unit
// Q16.16 matrix unit: multiply, multiply by transpose, add, subtract, scale
// and transpose over two 8x8 element stores
// ----------------------------------------------------------------------------
// Usage: a request is taken at a clock edge with start high and busy low.
// Load A and load B requests write one element of the A or B store, so loads
// stream at one per cycle with busy staying low.
// A start request runs the mode in op_mode on the sizes in the size
// registers; busy drops in the cycle that presents the final result.
// Each result element shows on the result ports for one cycle with
// result_valid_o high, in row-major order, last_o set on the final one.
// Multiply modes accumulate cols_a products per result element, all other
// modes one term, set by the single read port of each store; results pass
// the pipeline registers read, multiply, accumulate and saturate.
// A multiply with unequal inner sizes presents one error result in the cycle
// right after the start request and leaves busy low.
// The receiver always takes results; there is no backpressure.
// Reset sets op_mode to 0, all sizes to 1 and scale_factor to 1.0; the stores
// keep no reset value and must be loaded before use. Configuration writes go
// through the APB port and must be made while busy is low; it is not checked.
// ----------------------------------------------------------------------------
module small_matrix_arithmetic_unit import smau_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // request channel
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               command_i,
  input  logic [DIM_W-1:0]         row_i,
  input  logic [DIM_W-1:0]         col_i,
  input  logic signed [DATA_W-1:0] value_i,
  // result channel
  output logic                     result_valid_o,
  output logic signed [DATA_W-1:0] result_value_o,
  output logic [DIM_W-1:0]         out_row_o,
  output logic [DIM_W-1:0]         out_col_o,
  output logic                     last_o,
  output logic                     error_o,
  // configuration port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready
);

  logic [2:0]               op_mode_q;
  logic [SIZE_W-1:0]        rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic signed [DATA_W-1:0] scale_q;
  logic                     cfg_we;
  reg_e                     reg_idx;

  logic [DIM_W-1:0] ra_l, ca_l, rb_l, cb_l;
  logic [DIM_W-1:0] row_l, col_l, k_l;
  logic             mismatch, mode_ok;

  logic             req_acc, load_a, load_b, run_go, err_go;
  cmd_e             cmd;

  state_e           state_q, state_d;
  logic             issue_en;
  logic [DIM_W-1:0] i_q, j_q, k_q;
  logic             last_k, last_j, last_i, final_slot;

  logic [ADDR_W-1:0]        addr_a, addr_b;
  logic [DATA_W-1:0]        mem_a [DEPTH];
  logic [DATA_W-1:0]        mem_b [DEPTH];
  logic signed [DATA_W-1:0] rd_a_q, rd_b_q;
  tag_t                     tag_d, tag_q;
  logic                     fin_emit;

  // configuration registers
  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = reg_e'(paddr[PADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= MODE_MUL;
      rows_a_q  <= SIZE_W'(1);
      cols_a_q  <= SIZE_W'(1);
      rows_b_q  <= SIZE_W'(1);
      cols_b_q  <= SIZE_W'(1);
      scale_q   <= DATA_W'(32'sd65536);
    end else if (cfg_we) begin
      case (reg_idx)
        REG_OP_MODE: op_mode_q <= pwdata[2:0];
        REG_ROWS_A:  rows_a_q  <= pwdata[SIZE_W-1:0];
        REG_COLS_A:  cols_a_q  <= pwdata[SIZE_W-1:0];
        REG_ROWS_B:  rows_b_q  <= pwdata[SIZE_W-1:0];
        REG_COLS_B:  cols_b_q  <= pwdata[SIZE_W-1:0];
        REG_SCALE:   scale_q   <= pwdata[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      REG_OP_MODE: prdata = PDATA_W'(op_mode_q);
      REG_ROWS_A:  prdata = PDATA_W'(rows_a_q);
      REG_COLS_A:  prdata = PDATA_W'(cols_a_q);
      REG_ROWS_B:  prdata = PDATA_W'(rows_b_q);
      REG_COLS_B:  prdata = PDATA_W'(cols_b_q);
      REG_SCALE:   prdata = scale_q;
      default:     prdata = '0;
    endcase
  end

  // clamped sizes and loop bounds of the selected mode
  assign ra_l = dim_last(rows_a_q);
  assign ca_l = dim_last(cols_a_q);
  assign rb_l = dim_last(rows_b_q);
  assign cb_l = dim_last(cols_b_q);

  assign mode_ok  = (op_mode_q <= MODE_TRANS);
  assign mismatch = ((op_mode_q == MODE_MUL) && (ca_l != rb_l)) ||
                    ((op_mode_q == MODE_MUL_BT) && (ca_l != cb_l));

  always_comb begin
    case (op_mode_q)
      MODE_MUL: begin
        row_l = ra_l;
        col_l = cb_l;
        k_l   = ca_l;
      end
      MODE_MUL_BT: begin
        row_l = ra_l;
        col_l = rb_l;
        k_l   = ca_l;
      end
      MODE_TRANS: begin
        row_l = ca_l;
        col_l = ra_l;
        k_l   = '0;
      end
      default: begin
        row_l = ra_l;
        col_l = ca_l;
        k_l   = '0;
      end
    endcase
  end

  // request decode
  assign req_acc = start & ~busy;
  assign cmd     = cmd_e'(command_i);
  assign load_a  = req_acc && (cmd == CMD_LOAD_A);
  assign load_b  = req_acc && (cmd == CMD_LOAD_B);
  assign run_go  = req_acc && (cmd == CMD_START) && mode_ok && !mismatch;
  assign err_go  = req_acc && (cmd == CMD_START) && mismatch;

  // element and inner index counters
  assign last_k     = (k_q == k_l);
  assign last_j     = (j_q == col_l);
  assign last_i     = (i_q == row_l);
  assign final_slot = last_k & last_j & last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (run_go) begin
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else if (issue_en) begin
      if (!last_k) begin
        k_q <= k_q + DIM_W'(1);
      end else begin
        k_q <= '0;
        if (!last_j) begin
          j_q <= j_q + DIM_W'(1);
        end else begin
          j_q <= '0;
          i_q <= i_q + DIM_W'(1);
        end
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (run_go) state_d = ST_ISSUE;
      ST_ISSUE: if (final_slot) state_d = ST_DRAIN;
      ST_DRAIN: if (fin_emit) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer outputs
  always_comb begin
    busy     = (state_q != ST_IDLE);
    issue_en = (state_q == ST_ISSUE);
  end

  // store addresses per mode
  always_comb begin
    case (op_mode_q)
      MODE_MUL: begin
        addr_a = {i_q, k_q};
        addr_b = {k_q, j_q};
      end
      MODE_MUL_BT: begin
        addr_a = {i_q, k_q};
        addr_b = {j_q, k_q};
      end
      MODE_TRANS: begin
        addr_a = {j_q, i_q};
        addr_b = {i_q, j_q};
      end
      default: begin
        addr_a = {i_q, j_q};
        addr_b = {i_q, j_q};
      end
    endcase
  end

  // element stores, one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (load_a) begin
      mem_a[{row_i, col_i}] <= value_i;
    end
    rd_a_q <= mem_a[addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (load_b) begin
      mem_b[{row_i, col_i}] <= value_i;
    end
    rd_b_q <= mem_b[addr_b];
  end

  // tag aligned with the read data
  always_comb begin
    tag_d.valid = issue_en;
    tag_d.first = (k_q == '0);
    tag_d.lastk = last_k;
    tag_d.fin   = final_slot;
    tag_d.row   = i_q;
    tag_d.col   = j_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_d;
    end
  end

  // arithmetic and result register
  smau_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (op_mode_q),
    .scale_i        (scale_q),
    .rd_a_i         (rd_a_q),
    .rd_b_i         (rd_b_q),
    .tag_i          (tag_q),
    .err_req_i      (err_go),
    .result_valid_o (result_valid_o),
    .result_value_o (result_value_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .last_o         (last_o),
    .error_o        (error_o),
    .fin_emit_o     (fin_emit)
  );

endmodule
